### rtl/core/rpfd_pkg.sv
package rpfd_pkg;

    localparam int DUR_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W   = 7;
    localparam int BITS_W    = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_ON  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_OFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_ON   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_OFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REST      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SYM   = 3'd6;

    localparam logic EVENT_BEGIN = 1'b0;
    localparam logic EVENT_END   = 1'b1;

    typedef enum logic [1:0] {
        MODE_SEEK    = 2'd0,
        MODE_COLLECT = 2'd1,
        MODE_VERIFY  = 2'd2
    } mode_t;

    // true when |actual - nominal| <= tol
    function automatic logic near(
        input logic [DUR_W-1:0] actual,
        input logic [DUR_W-1:0] nominal,
        input logic [DUR_W-1:0] tol
    );
        logic [DUR_W-1:0] diff;
        diff = (actual > nominal) ? (actual - nominal) : (nominal - actual);
        return diff <= tol;
    endfunction

endpackage

### rtl/core/rpfd_ram.sv
module rpfd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/repeated_pulse_frame_decoder_unit.sv
// repeated pulse frame decoder
//
// input channel: one measured pulse or gap duration per transfer
// (in_valid / in_stall / duration). durations alternate on and off; each is
// judged against the rest, short and long nominals within the tolerance.
// output channel: begin and end events (out_valid / out_stall / event_kind,
// symbol_count, symbol_bits). a begin event follows the first repetition
// that matches the captured frame; an end event follows the first mismatch.
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready;
// write only while idle. index 7 is ignored.
// rate: one duration per cycle, back to back, while in_stall is low. an event
// shows on the output in the cycle after the duration transfer that caused it.
// the symbol store is read one symbol ahead (address = next position), so the
// per-symbol compare and the store write both happen in the cycle of each transfer.
// stall: the output register holds while out_stall is high; in_stall is
// raised only while an event waits and the receiver stalls.
// reset: seeking a first rest, registers at their reset values, no event
// pending. the symbol store is not cleared; only entries of the current
// frame are read.
module repeated_pulse_frame_decoder_unit #(
    parameter int MAX_SYMBOL_DEPTH = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // duration input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [rpfd_pkg::DUR_W-1:0]          duration,
    // event output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                event_kind,
    output logic [rpfd_pkg::COUNT_W-1:0]        symbol_count,
    output logic [rpfd_pkg::BITS_W-1:0]         symbol_bits,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rpfd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpfd_pkg::DUR_W-1:0]          cfg_data
);

    localparam int DEPTH  = MAX_SYMBOL_DEPTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DUR_W  = rpfd_pkg::DUR_W;

    // configuration registers
    logic [DUR_W-1:0]             short_on_reg;
    logic [DUR_W-1:0]             short_off_reg;
    logic [DUR_W-1:0]             long_on_reg;
    logic [DUR_W-1:0]             long_off_reg;
    logic [DUR_W-1:0]             rest_reg;
    logic [DUR_W-1:0]             tol_reg;
    logic [rpfd_pkg::COUNT_W-1:0] max_sym_reg;

    // decoder state
    rpfd_pkg::mode_t  mode_reg, mode_next;
    logic [CNT_W-1:0] frame_len_reg, frame_len_next;
    logic [CNT_W-1:0] position_reg, position_next;
    logic             phase_on_reg, phase_on_next;
    logic             active_reg, active_next;
    logic             ovf_reg, ovf_next;
    logic             skip_reg, skip_next;
    // frame image for reporting; the store below serves the per-symbol checks
    logic [DEPTH-1:0] image_reg, image_next;

    // output register
    logic                         out_valid_reg;
    logic                         kind_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [DEPTH-1:0]             bits_reg;

    logic             in_xfer;
    logic             out_xfer;
    logic             res_valid;
    logic             res_kind;
    logic [CNT_W-1:0] limit;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_bit;
    logic              rd_bit;

    logic             rest_hit;
    logic             short_hit;
    logic             long_hit;
    logic             nom_hit;
    logic [DUR_W-1:0] s_nom;
    logic [DUR_W-1:0] l_nom;
    logic [DUR_W-1:0] v_nom;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_on_reg  <= '0;
            short_off_reg <= '0;
            long_on_reg   <= '0;
            long_off_reg  <= '0;
            rest_reg      <= '0;
            tol_reg       <= '0;
            max_sym_reg   <= rpfd_pkg::COUNT_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                rpfd_pkg::CFG_SHORT_ON:  short_on_reg  <= cfg_data;
                rpfd_pkg::CFG_SHORT_OFF: short_off_reg <= cfg_data;
                rpfd_pkg::CFG_LONG_ON:   long_on_reg   <= cfg_data;
                rpfd_pkg::CFG_LONG_OFF:  long_off_reg  <= cfg_data;
                rpfd_pkg::CFG_REST:      rest_reg      <= cfg_data;
                rpfd_pkg::CFG_TOLERANCE: tol_reg       <= cfg_data;
                rpfd_pkg::CFG_MAX_SYM:   max_sym_reg   <= cfg_data[rpfd_pkg::COUNT_W-1:0];
                default:                 ;
            endcase
        end
    end

    // frame limit saturated to 1..DEPTH
    always_comb
    begin
        if (max_sym_reg == '0)
        begin
            limit = CNT_W'(1);
        end
        else if (max_sym_reg > rpfd_pkg::COUNT_W'(DEPTH))
        begin
            limit = CNT_W'(DEPTH);
        end
        else
        begin
            limit = CNT_W'(max_sym_reg);
        end
    end

    // duration compares
    assign s_nom     = phase_on_reg ? short_on_reg : short_off_reg;
    assign l_nom     = phase_on_reg ? long_on_reg  : long_off_reg;
    assign v_nom     = rd_bit ? l_nom : s_nom;
    assign rest_hit  = rpfd_pkg::near(duration, rest_reg, tol_reg);
    assign short_hit = rpfd_pkg::near(duration, s_nom, tol_reg);
    assign long_hit  = rpfd_pkg::near(duration, l_nom, tol_reg);
    assign nom_hit   = rpfd_pkg::near(duration, v_nom, tol_reg);

    // next state
    always_comb
    begin
        mode_next      = mode_reg;
        frame_len_next = frame_len_reg;
        position_next  = position_reg;
        phase_on_next  = phase_on_reg;
        active_next    = active_reg;
        ovf_next       = ovf_reg;
        skip_next      = skip_reg;
        image_next     = image_reg;
        res_valid      = 1'b0;
        res_kind       = rpfd_pkg::EVENT_BEGIN;
        wr_en          = 1'b0;
        wr_addr        = frame_len_reg[ADDR_W-1:0];
        wr_bit         = !short_hit;

        if (in_xfer)
        begin
            unique case (mode_reg)
                rpfd_pkg::MODE_COLLECT:
                begin
                    priority if (rest_hit)
                    begin
                        if (frame_len_reg == '0 || ovf_reg)
                        begin
                            frame_len_next = '0;
                            position_next  = '0;
                            phase_on_next  = 1'b1;
                            ovf_next       = 1'b0;
                            image_next     = '0;
                        end
                        else
                        begin
                            mode_next     = rpfd_pkg::MODE_VERIFY;
                            position_next = '0;
                            phase_on_next = 1'b1;
                            skip_next     = 1'b0;
                        end
                    end
                    else if (short_hit || long_hit)
                    begin
                        if (!ovf_reg && frame_len_reg < limit)
                        begin
                            wr_en = 1'b1;
                            image_next[frame_len_reg[ADDR_W-1:0]] = !short_hit;
                            frame_len_next = CNT_W'(frame_len_reg + 1'b1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        phase_on_next = !phase_on_reg;
                    end
                    else
                    begin
                        mode_next     = rpfd_pkg::MODE_SEEK;
                        phase_on_next = 1'b1;
                        ovf_next      = 1'b0;
                    end
                end

                rpfd_pkg::MODE_VERIFY:
                begin
                    priority if (skip_reg)
                    begin
                        skip_next     = 1'b0;
                        position_next = '0;
                        phase_on_next = 1'b1;
                    end
                    else if (nom_hit)
                    begin
                        position_next = CNT_W'(position_reg + 1'b1);
                        phase_on_next = !phase_on_reg;
                        if (position_next >= frame_len_reg)
                        begin
                            skip_next = 1'b1;
                            if (!active_reg)
                            begin
                                active_next = 1'b1;
                                res_valid   = 1'b1;
                                res_kind    = rpfd_pkg::EVENT_BEGIN;
                            end
                        end
                    end
                    else
                    begin
                        if (active_reg)
                        begin
                            active_next = 1'b0;
                            res_valid   = 1'b1;
                            res_kind    = rpfd_pkg::EVENT_END;
                        end
                        // mismatching item is judged again as a first rest
                        mode_next     = rpfd_pkg::MODE_SEEK;
                        phase_on_next = 1'b1;
                        ovf_next      = 1'b0;
                        skip_next     = 1'b0;
                        if (rest_hit)
                        begin
                            mode_next      = rpfd_pkg::MODE_COLLECT;
                            frame_len_next = '0;
                            position_next  = '0;
                            image_next     = '0;
                        end
                    end
                end

                default:
                begin
                    // seeking, and the unused mode code
                    mode_next     = rpfd_pkg::MODE_SEEK;
                    phase_on_next = 1'b1;
                    ovf_next      = 1'b0;
                    skip_next     = 1'b0;
                    if (rest_hit)
                    begin
                        mode_next      = rpfd_pkg::MODE_COLLECT;
                        frame_len_next = '0;
                        position_next  = '0;
                        image_next     = '0;
                    end
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= rpfd_pkg::MODE_SEEK;
            frame_len_reg <= '0;
            position_reg  <= '0;
            phase_on_reg  <= 1'b1;
            active_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            skip_reg      <= 1'b0;
            image_reg     <= '0;
        end
        else
        begin
            mode_reg      <= mode_next;
            frame_len_reg <= frame_len_next;
            position_reg  <= position_next;
            phase_on_reg  <= phase_on_next;
            active_reg    <= active_next;
            ovf_reg       <= ovf_next;
            skip_reg      <= skip_next;
            image_reg     <= image_next;
        end
    end

    // symbol store: written while collecting, read one position ahead so the
    // bit for the next verified symbol is ready; no write happens in verify
    rpfd_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_bit),
        .rd_addr (position_next[ADDR_W-1:0]),
        .rd_data (rd_bit)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer && res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_xfer)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && res_valid)
        begin
            kind_reg  <= res_kind;
            count_reg <= frame_len_reg;
            bits_reg  <= image_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign symbol_count = rpfd_pkg::COUNT_W'(count_reg);
    assign symbol_bits  = rpfd_pkg::BITS_W'(bits_reg);

`ifndef SYNTH
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frame_len_reg <= CNT_W'(DEPTH))
        else $error("frame length beyond store depth");

    a_verify_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == rpfd_pkg::MODE_VERIFY |-> frame_len_reg != '0 &&
        position_reg <= frame_len_reg)
        else $error("verify with empty frame or position past frame");

    a_begin_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && res_valid && res_kind == rpfd_pkg::EVENT_BEGIN |=> active_reg)
        else $error("begin event without active message");

    a_no_write_in_verify: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == rpfd_pkg::MODE_VERIFY |-> !wr_en)
        else $error("store written while verifying");

    a_event_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && res_valid |=> out_valid_reg && count_reg == $past(frame_len_reg))
        else $error("event lost at output register");
`endif

endmodule

### sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rpfd_pkg::*;

    localparam int SYMBOL_DEPTH = 64;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 150;

    // index 7 has no register behind it, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_EVENT
    } row_check_t;

    typedef struct packed {
        logic               kind;
        logic [COUNT_W-1:0] count;
        logic [BITS_W-1:0]  bits;
    } pulse_evt_t;

    typedef struct {
        logic [DUR_W-1:0] dur;
        row_check_t       chk;
        pulse_evt_t       evt;
    } pulse_row_t;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic [DUR_W-1:0]     duration   = '0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic                 event_kind;
    logic [COUNT_W-1:0]   symbol_count;
    logic [BITS_W-1:0]    symbol_bits;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [DUR_W-1:0]     cfg_data   = '0;

    // register copies seen by the decoder model
    logic [DUR_W-1:0]   short_on_cfg  = '0;
    logic [DUR_W-1:0]   short_off_cfg = '0;
    logic [DUR_W-1:0]   long_on_cfg   = '0;
    logic [DUR_W-1:0]   long_off_cfg  = '0;
    logic [DUR_W-1:0]   rest_cfg      = '0;
    logic [DUR_W-1:0]   tol_cfg       = '0;
    logic [COUNT_W-1:0] max_sym_cfg   = 7'd64;

    // decoder model state
    mode_t              mode_q     = MODE_SEEK;
    logic [BITS_W-1:0]  frame_bits = '0;
    logic [COUNT_W-1:0] frame_len  = '0;
    logic [COUNT_W-1:0] verify_pos = '0;
    logic               phase_on   = 1'b1;
    logic               msg_active = 1'b0;
    logic               overflow_q = 1'b0;
    logic               skip_rest  = 1'b0;

    // events the decoder owes us, oldest first
    pulse_evt_t pending_events[$];

    int in_idle_pct    = 0;
    int out_stall_pct  = 0;
    int items_sent     = 0;
    int begin_seen     = 0;
    int end_seen       = 0;
    int error_count    = 0;
    int settings_count = 0;

    // directed sequence, decoded with short 100/200, long 300/400, rest 1000, tol 5, limit 3
    pulse_row_t dir_rows [26] = '{
        '{20'hFFFFF, CHK_NONE,    '0},                             // top of range, no rest
        '{20'd0,     CHK_NONE,    '0},                             // bottom of range
        '{20'd1000,  CHK_NONE,    '0},                             // first rest
        '{20'd1000,  CHK_NONE,    '0},                             // adjacent rest, fresh frame
        '{20'd100,   CHK_PREDICT, '0},                             // short on
        '{20'd402,   CHK_PREDICT, '0},                             // long off
        '{20'd1003,  CHK_PREDICT, '0},                             // closing rest
        '{20'd98,    CHK_PREDICT, '0},
        '{20'd400,   CHK_EVENT,   '{EVENT_BEGIN, 7'd2, 64'h2}},    // first full match
        '{20'd12345, CHK_NONE,    '0},                             // skipped rest slot
        '{20'd100,   CHK_PREDICT, '0},
        '{20'd400,   CHK_NONE,    '0},                             // repeat while active
        '{20'd1000,  CHK_NONE,    '0},
        '{20'd300,   CHK_EVENT,   '{EVENT_END, 7'd2, 64'h2}},      // mismatch ends message
        '{20'd1000,  CHK_PREDICT, '0},
        '{20'd300,   CHK_PREDICT, '0},
        '{20'd200,   CHK_PREDICT, '0},
        '{20'd300,   CHK_PREDICT, '0},                             // frame at limit
        '{20'd200,   CHK_PREDICT, '0},                             // one past the limit
        '{20'd1000,  CHK_PREDICT, '0},                             // rest after overflow
        '{20'd103,   CHK_PREDICT, '0},
        '{20'd500,   CHK_PREDICT, '0},                             // bad symbol while collecting
        '{20'd1000,  CHK_PREDICT, '0},
        '{20'd100,   CHK_PREDICT, '0},
        '{20'd1000,  CHK_PREDICT, '0},
        '{20'd100,   CHK_EVENT,   '{EVENT_BEGIN, 7'd1, 64'h0}}     // single short symbol
    };

    repeated_pulse_frame_decoder_unit #(
        .MAX_SYMBOL_DEPTH(SYMBOL_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .duration     (duration),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_kind   (event_kind),
        .symbol_count (symbol_count),
        .symbol_bits  (symbol_bits),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // --------------------------------------------------------------------
    // decoder model
    // --------------------------------------------------------------------

    // absolute distance against the tolerance, done in int so no wrap
    function automatic bit close_to(input logic [DUR_W-1:0] a, input logic [DUR_W-1:0] nom);
        int gap;
        gap = int'(a) - int'(nom);
        if (gap < 0)
            gap = -gap;
        return gap <= int'(tol_cfg);
    endfunction

    // max_symbols clamped to 1..depth
    function automatic int frame_limit();
        if (max_sym_cfg == 0)
            return 1;
        if (int'(max_sym_cfg) > SYMBOL_DEPTH)
            return SYMBOL_DEPTH;
        return int'(max_sym_cfg);
    endfunction

    function automatic void open_frame();
        mode_q     = MODE_COLLECT;
        frame_len  = '0;
        verify_pos = '0;
        phase_on   = 1'b1;
        overflow_q = 1'b0;
        frame_bits = '0;
    endfunction

    // back to seeking, the current duration may already be the first rest
    function automatic void restart_seek(input logic [DUR_W-1:0] d);
        mode_q     = MODE_SEEK;
        phase_on   = 1'b1;
        overflow_q = 1'b0;
        skip_rest  = 1'b0;
        if (close_to(d, rest_cfg))
            open_frame();
    endfunction

    function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DUR_W-1:0] data);
        case (idx)
            CFG_SHORT_ON:  short_on_cfg  = data;
            CFG_SHORT_OFF: short_off_cfg = data;
            CFG_LONG_ON:   long_on_cfg   = data;
            CFG_LONG_OFF:  long_off_cfg  = data;
            CFG_REST:      rest_cfg      = data;
            CFG_TOLERANCE: tol_cfg       = data;
            CFG_MAX_SYM:   max_sym_cfg   = data[COUNT_W-1:0];
            default: ;
        endcase
    endfunction

    // one duration in, returns 1 with the event when the decoder must emit one
    function automatic bit decode_pulse(input logic [DUR_W-1:0] d, output pulse_evt_t evt);
        logic [DUR_W-1:0] s_nom;
        logic [DUR_W-1:0] l_nom;
        logic             is_long;
        bit               fire;
        fire = 1'b0;
        evt  = '0;
        case (mode_q)
            MODE_COLLECT:
            begin
                s_nom = phase_on ? short_on_cfg : short_off_cfg;
                l_nom = phase_on ? long_on_cfg  : long_off_cfg;
                // rest wins over symbols
                if (close_to(d, rest_cfg))
                begin
                    if (frame_len == 0 || overflow_q)
                        open_frame();
                    else
                    begin
                        mode_q     = MODE_VERIFY;
                        verify_pos = '0;
                        phase_on   = 1'b1;
                        skip_rest  = 1'b0;
                    end
                end
                else if (close_to(d, s_nom) || close_to(d, l_nom))
                begin
                    // short wins when both match
                    is_long = !close_to(d, s_nom);
                    if (!overflow_q && int'(frame_len) < frame_limit())
                    begin
                        frame_bits[frame_len[5:0]] = is_long;
                        frame_len = frame_len + 1'b1;
                    end
                    else
                        overflow_q = 1'b1;
                    phase_on = !phase_on;
                end
                else
                begin
                    mode_q     = MODE_SEEK;
                    phase_on   = 1'b1;
                    overflow_q = 1'b0;
                end
            end
            MODE_VERIFY:
            begin
                if (skip_rest)
                begin
                    skip_rest  = 1'b0;
                    verify_pos = '0;
                    phase_on   = 1'b1;
                end
                else
                begin
                    is_long = frame_bits[verify_pos[5:0]];
                    if (phase_on)
                        s_nom = is_long ? long_on_cfg : short_on_cfg;
                    else
                        s_nom = is_long ? long_off_cfg : short_off_cfg;
                    evt.count = frame_len;
                    evt.bits  = (frame_len >= 64) ? frame_bits
                              : frame_bits & ((64'd1 << frame_len) - 64'd1);
                    if (close_to(d, s_nom))
                    begin
                        verify_pos = verify_pos + 1'b1;
                        phase_on   = !phase_on;
                        if (verify_pos >= frame_len)
                        begin
                            skip_rest = 1'b1;
                            if (!msg_active)
                            begin
                                msg_active = 1'b1;
                                evt.kind   = EVENT_BEGIN;
                                fire       = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        if (msg_active)
                        begin
                            msg_active = 1'b0;
                            evt.kind   = EVENT_END;
                            fire       = 1'b1;
                        end
                        restart_seek(d);
                    end
                end
            end
            default: restart_seek(d);
        endcase
        if (!fire)
            evt = '0;
        return fire;
    endfunction

    // append an owed event at the tail of the queue
    function automatic void owe_event(input pulse_evt_t evt);
        pending_events.insert(pending_events.size(), evt);
    endfunction

    // --------------------------------------------------------------------
    // input side
    // --------------------------------------------------------------------

    // random gap, then hold the duration until the transfer happens
    task automatic push_duration(input logic [DUR_W-1:0] d,
                                 input row_check_t chk = CHK_PREDICT,
                                 input pulse_evt_t typed = '0);
        pulse_evt_t evt;
        bit         fire;
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        duration <= d;
        do
            @(posedge clk);
        while (in_stall);
        // transfer done at this edge
        fire = decode_pulse(d, evt);
        case (chk)
            CHK_PREDICT: if (fire) owe_event(evt);
            CHK_EVENT:   owe_event(typed);
            default: ;
        endcase
        items_sent++;
    endtask

    // sender holds off until every owed event is out, plus settle cycles
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_events.size() != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_cfg(idx, data);
    endtask

    // full register set, plus a junk write to the spare index
    task automatic load_settings(input logic [DUR_W-1:0] son, input logic [DUR_W-1:0] soff,
                                 input logic [DUR_W-1:0] lon, input logic [DUR_W-1:0] loff,
                                 input logic [DUR_W-1:0] rest, input logic [DUR_W-1:0] tol,
                                 input logic [DUR_W-1:0] max_word);
        write_reg(CFG_SHORT_ON, son);
        write_reg(CFG_SHORT_OFF, soff);
        write_reg(CFG_LONG_ON, lon);
        write_reg(CFG_LONG_OFF, loff);
        write_reg(CFG_REST, rest);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_MAX_SYM, max_word);
        write_reg(CFG_SPARE, 20'($urandom));
        cfg_valid <= 1'b0;
        settings_count++;
    endtask

    // a duration that lands anywhere inside the tolerance window
    function automatic logic [DUR_W-1:0] near_value(input logic [DUR_W-1:0] nom);
        int t;
        int v;
        t = int'(tol_cfg);
        v = int'(nom) - t + int'($urandom_range(0, 2 * t));
        if (v < 0)
            v = 0;
        else if (v > 20'hFFFFF)
            v = 20'hFFFFF;
        return v[DUR_W-1:0];
    endfunction

    // one frame worth of alternating on/off symbols, bad_at flips one (1-based)
    task automatic send_frame(input int n, input logic [63:0] pattern, input int bad_at);
        logic             lng;
        logic [DUR_W-1:0] nom;
        for (int k = 0; k < n; k++)
        begin
            lng = pattern[k % 64];
            if (k + 1 == bad_at)
                lng = !lng;
            if (k % 2 == 0)
                nom = lng ? long_on_cfg : short_on_cfg;
            else
                nom = lng ? long_off_cfg : short_off_cfg;
            push_duration(near_value(nom));
        end
    endtask

    // optional noise, then rest, frame, rest, a few repeats with their rest slots, then a break
    task automatic send_burst();
        int          n;
        int          lim;
        int          reps;
        int          pick;
        logic [63:0] pattern;
        lim  = frame_limit();
        pick = $urandom_range(0, 99);
        if (pick < 75)
            n = $urandom_range(1, (lim < 6) ? lim : 6);
        else if (pick < 90)
            n = $urandom_range(1, lim);
        else
            n = lim + $urandom_range(1, 3);
        pattern = {$urandom, $urandom};
        reps    = $urandom_range(0, 4);
        // leading line noise now and then
        if ($urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 3)) push_duration(20'($urandom));
        push_duration(near_value(rest_cfg));
        send_frame(n, pattern, 0);
        push_duration(near_value(rest_cfg));
        for (int r = 0; r < reps; r++)
        begin
            send_frame(n, pattern, ($urandom_range(0, 99) < 10) ? $urandom_range(1, n) : 0);
            push_duration(($urandom_range(0, 99) < 80) ? near_value(rest_cfg) : 20'($urandom));
        end
        // break the run with noise or a flipped first symbol
        if ($urandom_range(0, 1) == 0)
            push_duration(20'($urandom));
        else
            push_duration(near_value(pattern[0] ? short_on_cfg : long_on_cfg));
    endtask

    // --------------------------------------------------------------------
    // output side: random stall and in-order compare
    // --------------------------------------------------------------------

    function automatic void note_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        error_count++;
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    initial
    begin
        pulse_evt_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (pending_events.size() == 0)
                begin
                    error_count++;
                    $error("event with nothing owed: kind %0d count %0d bits 0x%0h",
                           event_kind, symbol_count, symbol_bits);
                end
                else
                begin
                    want = pending_events.pop_front();
                    if (event_kind !== want.kind)
                        note_mismatch("event_kind", want.kind, event_kind);
                    if (symbol_count !== want.count)
                        note_mismatch("symbol_count", want.count, symbol_count);
                    if (symbol_bits !== want.bits)
                        note_mismatch("symbol_bits", want.bits, symbol_bits);
                end
                if (event_kind == EVENT_BEGIN)
                    begin_seen++;
                else
                    end_seen++;
            end
            out_stall <= ($urandom_range(0, 99) < out_stall_pct);
        end
    end

    // --------------------------------------------------------------------
    // main sequence
    // --------------------------------------------------------------------

    initial
    begin
        int phase_end;
        bit held;
        held = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, no idling
        load_settings(20'd100, 20'd200, 20'd300, 20'd400, 20'd1000, 20'd5, 20'd3);
        foreach (dir_rows[i])
            push_duration(dir_rows[i].dur, dir_rows[i].chk, dir_rows[i].evt);

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            // block must be quiet before registers move
            drain(4);
            case (ph)
                0: load_settings(20'd100, 20'd120, 20'd300, 20'd330, 20'd1000, 20'd10, 20'd64);
                // tight limit, exact match only, lots of overflow
                1: load_settings(20'd50, 20'd60, 20'd150, 20'd170, 20'd700, 20'd0, 20'd3);
                // nominals at the range ends, limit written as zero
                2: load_settings(20'd0, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'h7FFFF, 20'd0, 20'd0);
                // short and long windows overlap; limit above depth with junk high bits
                3: load_settings(20'd200, 20'd210, 20'd205, 20'd215, 20'd500, 20'd12,
                                 {13'($urandom), 7'd127});
                // everything looks like a rest
                4: load_settings(20'd100, 20'd120, 20'd300, 20'd330, 20'd1000, 20'hFFFFF,
                                 20'd64);
                // rest window overlaps long on
                5: load_settings(20'd100, 20'd150, 20'd300, 20'd350, 20'd310, 20'd15, 20'd5);
                6: load_settings(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                                 20'($urandom), 20'($urandom_range(0, 2000)), 20'($urandom));
                default: load_settings(20'd400, 20'd800, 20'd1200, 20'd1600, 20'd5000, 20'd0,
                                       20'd64);
            endcase
            case (ph % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 72; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 72; end
                default: begin in_idle_pct = 23; out_stall_pct = 23; end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                send_burst();
                // once, sender waits mid-phase for every owed event
                if (ph == 2 && !held && items_sent > phase_end - PHASE_ITEMS / 2)
                begin
                    drain(0);
                    held = 1'b1;
                end
            end
        end

        drain(8);
        $display("sent %0d durations under %0d register settings", items_sent, settings_count);
        $display("saw %0d begin and %0d end events", begin_seen, end_seen);
        if (error_count == 0 && pending_events.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // hard stop in case the decoder hangs
    initial
    begin
        #400_000;
        $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/core/rpfd_pkg.sv
rtl/core/rpfd_ram.sv
rtl/core/repeated_pulse_frame_decoder_unit.sv
sim/tb_top.sv
